/* rtl/olpir_pkg.sv */
//------------------------------------------------------------------------------
// olpir_pkg
// Operation, status and cell command codes for the ordered list.
//------------------------------------------------------------------------------
`default_nettype none

package olpir_pkg;

	typedef enum logic [2:0] {
		OP_APPEND      = 3'd0,
		OP_INSERT      = 3'd1,
		OP_REMOVE_LAST = 3'd2,
		OP_REMOVE_AT   = 3'd3,
		OP_READ        = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_INS  = 2'd1,
		CMD_REM  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
	} cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/olpir_cell.sv */
//------------------------------------------------------------------------------
// olpir_cell
// One list slot: loads the new word, takes its left neighbor on insert or
// its right neighbor on remove, otherwise holds.
//------------------------------------------------------------------------------
`default_nettype none

module olpir_cell #(
	parameter int IDX        = 0,
	parameter int AW         = 6,
	parameter int DATA_WIDTH = 32
) (
	input  wire                       clk,
	input  wire olpir_pkg::cell_cmd_t cmd,
	input  wire  [AW-1:0]             at,
	input  wire  [DATA_WIDTH-1:0]     word,
	input  wire  [DATA_WIDTH-1:0]     left_val,
	input  wire  [DATA_WIDTH-1:0]     right_val,
	output logic [DATA_WIDTH-1:0]     val
);
	import olpir_pkg::*;

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] val_d;

	always_comb begin
		val_d = val_q;
		unique case (cmd.kind)
			CMD_INS: begin
				if (MY_IDX == at) val_d = word;
				else if (MY_IDX > at) val_d = left_val;
			end
			CMD_REM: begin
				if (MY_IDX >= at) val_d = right_val;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule

`default_nettype wire

/* rtl/ordered_list_positional_insert_remove.sv */
//------------------------------------------------------------------------------
// ordered_list_positional_insert_remove
// Bounded ordered list held in a row of cells with positional insert/remove.
//------------------------------------------------------------------------------
// Usage:
//   Command channel: op, position and data_in transfer at a clock edge where
//   start is high and busy is low. busy is always low: a command may be
//   issued every cycle.
//   Result channel: done is high for one cycle, in the cycle after the
//   command transfer; status, data_out, entry_count, first_value and
//   last_value are valid in that cycle only. The receiver cannot stall.
//   Throughput is one command per cycle: every cell of the row takes its
//   neighbor's word in the same cycle, so an insert or a remove anywhere in
//   the list completes in a single shift.
//   Reset clears the entry count and the result strobe; the list is empty
//   after reset and needs no clearing pass.
//------------------------------------------------------------------------------
`default_nettype none

module ordered_list_positional_insert_remove #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire  [2:0]            op,
	input  wire  [5:0]            position,
	input  wire  [DATA_WIDTH-1:0] data_in,
	output logic                  done,
	output logic [1:0]            status,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic [CW-1:0]         entry_count,
	output logic [DATA_WIDTH-1:0] first_value,
	output logic [DATA_WIDTH-1:0] last_value
);
	import olpir_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int PW = (CW > 6) ? CW : 6;

	logic [DATA_WIDTH-1:0] cell_val [DEPTH];
	logic [CW-1:0]         cnt_q, cnt_d;
	logic                  vld_q;
	status_t               status_q, status_d;
	logic [DATA_WIDTH-1:0] data_q, data_d;
	cell_cmd_t             cmd;
	logic [AW-1:0]         at;
	logic [AW-1:0]         pos_a;
	logic [AW-1:0]         tail_a;
	logic                  go, full, empty, pos_lt;

	assign busy   = 1'b0;
	assign go     = start && !busy;
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign pos_lt = (PW'(position) < PW'(cnt_q));
	assign pos_a  = AW'(position);
	assign tail_a = AW'(cnt_q - CW'(1));

	always_comb begin
		cmd.kind = CMD_NONE;
		at       = tail_a;
		cnt_d    = cnt_q;
		status_d = ST_OK;
		data_d   = '0;
		unique case (op_t'(op))
			OP_APPEND, OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.kind = CMD_INS;
					at       = (op_t'(op) == OP_INSERT && pos_lt) ? pos_a : AW'(cnt_q);
					cnt_d    = cnt_q + CW'(1);
				end
			end
			OP_REMOVE_LAST, OP_REMOVE_AT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					cmd.kind = CMD_REM;
					at       = (op_t'(op) == OP_REMOVE_AT && pos_lt) ? pos_a : tail_a;
					data_d   = cell_val[at];
					cnt_d    = cnt_q - CW'(1);
				end
			end
			OP_READ: begin
				if (empty) status_d = ST_EMPTY;
				else if (!pos_lt) status_d = ST_RANGE;
				else data_d = cell_val[pos_a];
			end
			default: ;
		endcase
		if (!go) begin
			cmd.kind = CMD_NONE;
			cnt_d    = cnt_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		olpir_cell #(
			.IDX       (i),
			.AW        (AW),
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.at       (at),
			.word     (data_in),
			.left_val ((i == 0) ? cell_val[0] : cell_val[(i == 0) ? 0 : i - 1]),
			.right_val(cell_val[(i == DEPTH - 1) ? i : i + 1]),
			.val      (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vld_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			vld_q <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q <= status_d;
			data_q   <= data_d;
		end
	end

	assign done        = vld_q;
	assign status      = status_q;
	assign data_out    = data_q;
	assign entry_count = cnt_q;
	assign first_value = empty ? '0 : cell_val[0];
	assign last_value  = empty ? '0 : cell_val[tail_a];

endmodule

`default_nettype wire

/* verif/tb_ordered_list_positional_insert_remove.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_ordered_list_positional_insert_remove
// Self-checking bench for the bounded ordered list with positional
// insert/remove. A generator fills a queue of commands: a directed opening,
// then random fill and drain runs that keep reaching the full and empty
// list. A driver issues them with random gaps, and a monitor predicts each
// result from a shadow copy of the list and checks each response in order.
//------------------------------------------------------------------------------
module tb_ordered_list_positional_insert_remove;
	import olpir_pkg::*;

	localparam int DEPTH          = 64;
	localparam int DATA_WIDTH     = 32;
	localparam int CW             = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS   = 1500;
	localparam int WATCHDOG_LIMIT = 200;

	localparam logic [2:0] OP_NOP_FIRST = 3'd5;
	localparam logic [2:0] OP_NOP_LAST  = 3'd7;

	typedef struct packed {
		logic [2:0]            op;
		logic [5:0]            pos;
		logic [DATA_WIDTH-1:0] data;
	} list_cmd_t;

	typedef struct packed {
		status_t               status;
		logic [DATA_WIDTH-1:0] data;
		logic [CW-1:0]         count;
		logic [DATA_WIDTH-1:0] head;
		logic [DATA_WIDTH-1:0] tail;
	} list_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  start    = 1'b0;
	logic [2:0]            op       = '0;
	logic [5:0]            position = '0;
	logic [DATA_WIDTH-1:0] data_in  = '0;
	logic                  busy;
	logic                  done;
	logic [1:0]            status;
	logic [DATA_WIDTH-1:0] data_out;
	logic [CW-1:0]         entry_count;
	logic [DATA_WIDTH-1:0] first_value;
	logic [DATA_WIDTH-1:0] last_value;

	ordered_list_positional_insert_remove #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.position(position),
		.data_in(data_in),
		.done(done),
		.status(status),
		.data_out(data_out),
		.entry_count(entry_count),
		.first_value(first_value),
		.last_value(last_value)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// shadow list
	logic [DATA_WIDTH-1:0] list_words [DEPTH];
	int                    list_len = 0;

	list_cmd_t    pending_cmds [$];
	list_result_t expected_results [$];
	int           total_cmds     = 0;
	int           accepted_total = 0;
	int           quiet_cycles   = 0;
	int           errors         = 0;
	logic         cmd_taken      = 1'b0;
	int           gen_len        = 0;

	function automatic list_result_t apply_list_op(input list_cmd_t c);
		list_result_t r;
		int at;
		int i;
		r.status = ST_OK;
		r.data = '0;
		case (c.op)
			OP_APPEND, OP_INSERT: begin
				if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					at = list_len;
					if (c.op == OP_INSERT && c.pos < list_len)
						at = c.pos;
					for (i = list_len; i > at; i--)
						list_words[i] = list_words[i-1];
					list_words[at] = c.data;
					list_len++;
				end
			end
			OP_REMOVE_LAST, OP_REMOVE_AT: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					at = list_len - 1;
					if (c.op == OP_REMOVE_AT && c.pos < list_len)
						at = c.pos;
					r.data = list_words[at];
					for (i = at; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			OP_READ: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else if (c.pos >= list_len)
					r.status = ST_RANGE;
				else
					r.data = list_words[c.pos];
			end
			default: begin
			end
		endcase
		r.count = list_len[CW-1:0];
		r.head = (list_len != 0) ? list_words[0] : '0;
		r.tail = (list_len != 0) ? list_words[list_len-1] : '0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
			input logic [DATA_WIDTH-1:0] want);
		errors++;
		$display("MISMATCH @%0t %s: got %h, expected %h", $time, what, got, want);
	endtask

	task automatic queue_cmd(input logic [2:0] c_op, input logic [5:0] c_pos,
			input logic [DATA_WIDTH-1:0] c_data);
		list_cmd_t c;
		c.op = c_op;
		c.pos = c_pos;
		c.data = c_data;
		pending_cmds.push_back(c);
		total_cmds++;
		if ((c_op == OP_APPEND || c_op == OP_INSERT) && gen_len < DEPTH)
			gen_len++;
		else if ((c_op == OP_REMOVE_LAST || c_op == OP_REMOVE_AT) && gen_len > 0)
			gen_len--;
	endtask

	// driver
	int        hold_cycles = 0;
	logic      no_idle     = 1'b0;
	list_cmd_t next_cmd;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || cmd_taken) begin
				if (hold_cycles > 0) begin
					start <= 1'b0;
					hold_cycles--;
				end else if (pending_cmds.size() != 0) begin
					next_cmd = pending_cmds.pop_front();
					start <= 1'b1;
					op <= next_cmd.op;
					position <= next_cmd.pos;
					data_in <= next_cmd.data;
					if ($urandom_range(0, 31) == 0)
						no_idle = !no_idle;
					hold_cycles = no_idle ? 0 : $urandom_range(0, 16);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	list_result_t want;
	list_cmd_t    seen_cmd;

	always @(posedge clk) begin
		cmd_taken <= start && !busy;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no command pending", '0, '0);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", DATA_WIDTH'(status),
								DATA_WIDTH'(want.status));
					if (data_out !== want.data)
						report_mismatch("data_out", data_out, want.data);
					if (entry_count !== want.count)
						report_mismatch("entry_count", DATA_WIDTH'(entry_count),
								DATA_WIDTH'(want.count));
					if (first_value !== want.head)
						report_mismatch("first_value", first_value, want.head);
					if (last_value !== want.tail)
						report_mismatch("last_value", last_value, want.tail);
				end
			end
			if (start && !busy) begin
				seen_cmd.op = op;
				seen_cmd.pos = position;
				seen_cmd.data = data_in;
				expected_results.push_back(apply_list_op(seen_cmd));
				accepted_total <= accepted_total + 1;
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("ordered_list_positional_insert_remove verification failed");
		$finish;
	end

	// stimulus and end of run
	int         random_items = 0;
	logic       fill_mode    = 1'b1;
	int         r;
	logic [2:0] pick_op;
	logic [5:0] pick_pos;
	logic [DATA_WIDTH-1:0] pick_data;

	initial begin
		// empty-list cases
		queue_cmd(OP_READ, 6'd0, '0);
		queue_cmd(OP_REMOVE_LAST, 6'd0, '0);
		queue_cmd(OP_REMOVE_AT, 6'd63, '0);
		queue_cmd(OP_NOP_FIRST, 6'd0, 32'hDEADBEEF);
		queue_cmd(OP_NOP_FIRST + 3'd1, 6'd63, '1);
		queue_cmd(OP_NOP_LAST, 6'd21, 32'h0000FFFF);
		// removing the only entry empties head and tail
		queue_cmd(OP_APPEND, 6'd0, '1);
		queue_cmd(OP_REMOVE_AT, 6'd0, '0);
		queue_cmd(OP_APPEND, 6'd0, '0);
		queue_cmd(OP_INSERT, 6'd63, 32'hA5A5A5A5);
		queue_cmd(OP_INSERT, 6'd0, 32'h5A5A5A5A);
		queue_cmd(OP_READ, 6'd63, '0);
		queue_cmd(OP_READ, 6'd1, '0);
		queue_cmd(OP_NOP_LAST, 6'd2, '1);
		queue_cmd(OP_REMOVE_AT, 6'd1, '0);
		queue_cmd(OP_REMOVE_AT, 6'd63, '0);
		queue_cmd(OP_REMOVE_LAST, 6'd0, '0);
		queue_cmd(OP_INSERT, 6'd0, 32'h12345678);
		queue_cmd(OP_READ, 6'd0, '0);
		queue_cmd(OP_REMOVE_LAST, 6'd42, '0);

		// fill and drain runs so full and empty are hit repeatedly
		while (random_items < RANDOM_ITEMS) begin
			if (gen_len == DEPTH)
				fill_mode = 1'b0;
			else if (gen_len == 0)
				fill_mode = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				fill_mode = !fill_mode;
			r = $urandom_range(0, 99);
			if (r < 3)
				pick_op = 3'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
			else if ((r < 73) == fill_mode && r < 88)
				pick_op = $urandom_range(0, 1) ? OP_INSERT : OP_APPEND;
			else if (r < 88)
				pick_op = $urandom_range(0, 1) ? OP_REMOVE_AT : OP_REMOVE_LAST;
			else
				pick_op = OP_READ;
			case ($urandom_range(0, 4))
				0: pick_pos = 6'($urandom_range(0, 63));
				1: pick_pos = '0;
				2: pick_pos = 6'((gen_len > 0) ? gen_len - 1 : 0);
				3: pick_pos = 6'((gen_len < DEPTH) ? gen_len : DEPTH - 1);
				default: pick_pos = (gen_len > 0) ? 6'($urandom_range(0, gen_len - 1))
						: 6'($urandom_range(0, 63));
			endcase
			case ($urandom_range(0, 15))
				0: pick_data = '0;
				1: pick_data = '1;
				default: pick_data = $urandom;
			endcase
			queue_cmd(pick_op, pick_pos, pick_data);
			if (pick_op <= OP_READ)
				random_items++;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_total < total_cmds || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		if (errors == 0)
			$display("ordered_list_positional_insert_remove verification clean");
		else
			$display("ordered_list_positional_insert_remove verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/olpir_pkg.sv
rtl/olpir_cell.sv
rtl/ordered_list_positional_insert_remove.sv
verif/tb_ordered_list_positional_insert_remove.sv
